// ----- sv/interval_timer_three_channel_top_macros.svh -----
// Assertion macros shared by the timer checker.
`ifndef INTERVAL_TIMER_THREE_CHANNEL_TOP_MACROS_SVH
`define INTERVAL_TIMER_THREE_CHANNEL_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ITC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
// Next-cycle implication checked outside reset.
`define ITC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

// ----- sv/itc_pkg.sv -----
// Package with types and constants of the interval timer.
`timescale 1ns / 1ps
package itc_pkg;
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] PORT_CTRL  = 2'd3;
	localparam logic [1:0] ACC_LATCH  = 2'd0;
	localparam logic [1:0] ACC_LSB    = 2'd1;
	localparam logic [1:0] ACC_MSB    = 2'd2;
	localparam logic [1:0] ACC_BOTH   = 2'd3;
	localparam logic [2:0] PH_RELOAD  = 3'd0;
	localparam logic [2:0] PH_GATE    = 3'd1;
	localparam logic [2:0] PH_LOAD    = 3'd2;
	localparam logic [2:0] PH_COUNT   = 3'd3;
	localparam logic [7:0] CTRL_READ  = 8'hFF;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] port;
		logic [7:0] write_data;
		logic [2:0] gate_levels;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] out_levels;
		logic [2:0] out_changed;
	} rsp_t;

	// Per-lane command decoded from one request.
	typedef struct packed {
		logic       tick;
		logic       rd;
		logic       wr;
		logic       ctrl;
		logic [7:0] data;
		logic       gate;
	} lane_cmd_t;

	// Per-lane result.
	typedef struct packed {
		logic [7:0] rdata;
		logic       level;
		logic       changed;
	} lane_res_t;
endpackage

// ----- sv/itc_if.sv -----
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface itc_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- sv/itc_lane.sv -----
// One timer channel: state registers and next-state logic for one request.
`timescale 1ns / 1ps
module itc_lane #(
	parameter logic [1:0] CHAN = 2'd0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  itc_pkg::lane_cmd_t  cmd,
	output itc_pkg::lane_res_t  res
);
	import itc_pkg::*;

	logic [5:0]  mode_q;
	logic [15:0] reload_q, count_q, latched_q, staged_q;
	logic        lol_q, armed_q, held_q, out_q, pgate_q, bph_q, first_q;
	logic [2:0]  ph_q;

	logic [5:0]  mode_d;
	logic [15:0] reload_d, count_d, latched_d, staged_d;
	logic        lol_d, armed_d, held_d, out_d, pgate_d, bph_d, first_d, chg;
	logic [2:0]  ph_d, m;
	logic [7:0]  rdata;

	assign m = mode_q[3:1];

	// Next state of the channel for the current request.
	always_comb begin
		logic [2:0] nm;
		mode_d = mode_q; reload_d = reload_q; count_d = count_q;
		latched_d = latched_q; staged_d = staged_q; lol_d = lol_q;
		armed_d = armed_q; held_d = held_q; out_d = out_q; pgate_d = pgate_q;
		bph_d = bph_q; first_d = first_q; ph_d = ph_q; chg = 1'b0; rdata = '0;
		nm = cmd.data[3:1];
		if (cmd.tick) begin
			// Gate edge sampling.
			if (ph_q != PH_RELOAD) begin
				if (!pgate_q && cmd.gate) begin
					if (m != 3'd0 && m != 3'd4) ph_d = PH_LOAD;
				end else if (pgate_q && !cmd.gate) begin
					if (m[1]) begin
						if (!out_q) chg = 1'b1;
						out_d = 1'b1;
						ph_d = PH_GATE;
					end else if (m == 3'd4) begin
						ph_d = PH_GATE;
					end
				end
			end
			pgate_d = cmd.gate;
			if (ph_d == PH_LOAD) begin
				count_d = reload_q;
				out_d = lol_q;
				ph_d = PH_COUNT;
			end else if (ph_d == PH_COUNT && armed_q &&
				(m == 3'd0 || m[1])) begin
				count_d = mode_q[0] ? count_q : count_q - 16'd1;
				if (!held_q) latched_d = count_d;
				if (m == 3'd0) begin
					if (count_d == 16'd0) begin
						if (!out_d) chg = 1'b1;
						out_d = 1'b1;
					end
				end else if (!m[0]) begin
					if (count_d == 16'd1) begin
						if (out_d) chg = 1'b1;
						out_d = 1'b0;
						lol_d = 1'b1;
						ph_d = PH_LOAD;
					end
				end else if (count_d == 16'd0) begin
					chg = 1'b1;
					out_d = !out_d;
					count_d = reload_q;
					ph_d = PH_LOAD;
				end
			end
		end else if (cmd.rd) begin
			case (mode_q[5:4])
				ACC_LSB: begin held_d = 1'b0; rdata = latched_q[7:0]; end
				ACC_MSB: begin held_d = 1'b0; rdata = latched_q[15:8]; end
				ACC_BOTH: begin
					if (!bph_q) begin
						rdata = latched_q[7:0]; bph_d = 1'b1;
					end else begin
						held_d = 1'b0; rdata = latched_q[15:8]; bph_d = 1'b0;
					end
				end
				default: rdata = '0;
			endcase
		end else if (cmd.wr && cmd.ctrl) begin
			if (cmd.data[7:6] == CHAN) begin
				if (cmd.data[5:4] == ACC_LATCH) begin
					latched_d = count_q; held_d = 1'b1;
				end else begin
					mode_d = cmd.data[5:0]; held_d = 1'b0; count_d = '0;
					ph_d = PH_RELOAD; first_d = 1'b1;
					if (nm == 3'd0) begin
						if (out_q) chg = 1'b1;
						out_d = 1'b0; lol_d = 1'b0;
					end else begin
						if (!out_q) chg = 1'b1;
						out_d = 1'b1; lol_d = nm[1];
					end
				end
				bph_d = 1'b0;
			end
		end else if (cmd.wr) begin
			logic ld;
			ld = 1'b0;
			case (mode_q[5:4])
				ACC_LSB: begin staged_d = {8'd0, cmd.data}; ld = 1'b1; end
				ACC_MSB: begin staged_d = {cmd.data, 8'd0}; ld = 1'b1; end
				ACC_BOTH: begin
					if (!bph_q) begin
						staged_d = {staged_q[15:8], cmd.data}; bph_d = 1'b1;
						if (m == 3'd0) begin
							if (out_q) chg = 1'b1;
							out_d = 1'b0; ph_d = PH_RELOAD;
						end
					end else begin
						staged_d = {cmd.data, staged_q[7:0]}; ld = 1'b1; bph_d = 1'b0;
					end
				end
				default: ld = 1'b0;
			endcase
			if (ld) begin
				reload_d = staged_d;
				if (first_q) begin
					ph_d = PH_LOAD; first_d = 1'b0;
				end else if (m == 3'd0 || m == 3'd4) begin
					ph_d = PH_LOAD;
				end
				armed_d = 1'b1;
			end
		end
	end

	// Channel state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0; reload_q <= '0; count_q <= '0; latched_q <= '0;
			staged_q <= '0; lol_q <= 1'b0; armed_q <= 1'b0; held_q <= 1'b0;
			out_q <= 1'b0; pgate_q <= 1'b0; bph_q <= 1'b0; first_q <= 1'b1;
			ph_q <= PH_RELOAD;
		end else if (step) begin
			mode_q <= mode_d; reload_q <= reload_d; count_q <= count_d;
			latched_q <= latched_d; staged_q <= staged_d; lol_q <= lol_d;
			armed_q <= armed_d; held_q <= held_d; out_q <= out_d;
			pgate_q <= pgate_d; bph_q <= bph_d; first_q <= first_d; ph_q <= ph_d;
		end
	end

	assign res.rdata   = rdata;
	assign res.level   = out_d;
	assign res.changed = chg;
endmodule

// ----- sv/itc_merge.sv -----
// Merges the lane results into one response word.
`timescale 1ns / 1ps
module itc_merge #(
	parameter int NUM_CHANNELS = 3
) (
	input  itc_pkg::req_t                        req,
	input  itc_pkg::lane_res_t [NUM_CHANNELS-1:0] lres,
	output itc_pkg::rsp_t                        rsp
);
	import itc_pkg::*;

	// Pick the addressed lane's read byte (or the control read value for other ports) and gather level and change bits.
	always_comb begin
		rsp = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			rsp.out_levels[i]  = lres[i].level;
			rsp.out_changed[i] = lres[i].changed;
			if (req.kind == KIND_READ && req.port == 2'(i))
				rsp.read_data = lres[i].rdata;
		end
		if (req.kind == KIND_READ && {30'd0, req.port} >= NUM_CHANNELS)
			rsp.read_data = CTRL_READ;
	end
endmodule

// ----- sv/interval_timer_three_channel_top.sv -----
// Three-channel interval timer: request channel in, response channel out.
// Usage:
//   Each request carries kind (tick, bus read, bus write), port, write_data
//   and gate_levels. Every accepted request yields exactly one response with
//   read_data, out_levels and out_changed.
//   The response is registered and shows in the cycle after accept.
//   Throughput: one request per cycle; each channel lane updates its state
//   in the accept cycle, and the merge stage feeds a single output register.
//   A request is taken while the output register is empty or being drained,
//   so a stalled receiver holds the response and stops new requests only
//   while the register is full and not taken.
//   Reset: all channels return to waiting for a reload with zero counts and
//   low outputs; the output register is emptied.
`timescale 1ns / 1ps
module interval_timer_three_channel_top #(
	parameter int NUM_CHANNELS = 3
) (
	input logic clk,
	input logic arst_n,
	itc_if.sink   req,
	itc_if.source rsp
);
	import itc_pkg::*;

	logic                             step;
	lane_cmd_t [NUM_CHANNELS-1:0]     cmd;
	lane_res_t [NUM_CHANNELS-1:0]     lres;
	rsp_t                             merged;
	logic                             vld_q;
	rsp_t                             rsp_q;
	req_t                             r;

	assign r = req.data;
	assign req.ready = !vld_q || rsp.ready;
	assign step = req.valid && req.ready;

	// Channel lanes.
	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
		always_comb begin
			cmd[i].tick = r.kind == KIND_TICK;
			cmd[i].rd   = r.kind == KIND_READ && r.port == 2'(i);
			cmd[i].wr   = r.kind == KIND_WRITE && (r.port == 2'(i) || r.port == PORT_CTRL);
			cmd[i].ctrl = r.port == PORT_CTRL;
			cmd[i].data = r.write_data;
			cmd[i].gate = r.gate_levels[i];
		end
		itc_lane #(.CHAN(2'(i))) u_lane (
			.clk(clk), .arst_n(arst_n), .step(step), .cmd(cmd[i]), .res(lres[i])
		);
	end

	itc_merge #(.NUM_CHANNELS(NUM_CHANNELS)) u_merge (
		.req(r), .lres(lres), .rsp(merged)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (step) begin
			vld_q <= 1'b1;
		end else if (rsp.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_q <= merged;
		end
	end

	assign rsp.valid = vld_q;
	assign rsp.data  = rsp_q;
endmodule

// ----- sv/itc_checker.sv -----
// Port-level checker for the interval timer and its bind.
`timescale 1ns / 1ps
`include "interval_timer_three_channel_top_macros.svh"
module itc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] req_kind,
	input logic [7:0] rsp_read_data,
	input logic [2:0] rsp_changed
);
	import itc_pkg::*;

	`ITC_ASSERT_NEXT(a_rsp_follows, clk, arst_n, req_valid && req_ready, rsp_valid, "no response")
	`ITC_ASSERT_IMP(a_ready_free, clk, arst_n, !rsp_valid, req_ready, "ready low while empty")
	`ITC_ASSERT_NEXT(a_tick_zero, clk, arst_n, req_valid && req_ready && req_kind != KIND_READ, rsp_read_data == 8'd0, "nonzero read byte")
	`ITC_ASSERT_NEXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_changed), "stalled response moved")
endmodule

bind interval_timer_three_channel_top itc_checker u_itc_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .req_kind(req.data.kind),
	.rsp_read_data(rsp.data.read_data), .rsp_changed(rsp.data.out_changed)
);

// ----- dv/timer_check.sv -----
// Checker that predicts and compares every response of the interval timer.
`timescale 1ns / 1ps
module timer_check (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input itc_pkg::req_t req_data,
	input logic rsp_valid,
	input logic rsp_ready,
	input itc_pkg::rsp_t rsp_data,
	output int errors,
	output int pending,
	output int checked
);
	import itc_pkg::*;

	// Per-channel timer state.
	typedef struct {
		logic [5:0]  mode_word;
		logic [15:0] reload_val;
		logic [15:0] count_val;
		logic [15:0] latched;
		logic [15:0] staged;
		logic        load_level;
		logic        armed;
		logic        held;
		logic        level;
		logic        prev_gate;
		logic        byte_hi;
		logic        first_load;
		logic [2:0]  phase;
	} timer_chan_t;

	timer_chan_t chans[3];
	logic [2:0] changed;
	rsp_t expected_rsps[$];

	function automatic logic [2:0] timer_mode(int n);
		return chans[n].mode_word[3:1];
	endfunction

	function automatic void set_level(int n, logic lvl);
		if (chans[n].level != lvl) begin
			chans[n].level = lvl;
			changed[n] = 1'b1;
		end
	endfunction

	function automatic void begin_load(int n);
		logic [2:0] m;
		m = timer_mode(n);
		chans[n].reload_val = chans[n].staged;
		if (chans[n].first_load) begin
			chans[n].phase = PH_LOAD;
			chans[n].first_load = 1'b0;
		end else if (m == 3'd0 || m == 3'd4) begin
			chans[n].phase = PH_LOAD;
		end
		chans[n].armed = 1'b1;
	endfunction

	function automatic void step_down(int n);
		if (!chans[n].mode_word[0])
			chans[n].count_val = chans[n].count_val - 16'd1;
		if (!chans[n].held)
			chans[n].latched = chans[n].count_val;
	endfunction

	function automatic void count_chan(int n);
		logic [2:0] m;
		m = timer_mode(n);
		if (!chans[n].armed)
			return;
		if (m == 3'd0) begin
			step_down(n);
			if (chans[n].count_val == 16'd0)
				set_level(n, 1'b1);
		end else if (m == 3'd2 || m == 3'd6) begin
			step_down(n);
			if (chans[n].count_val == 16'd1) begin
				set_level(n, 1'b0);
				chans[n].load_level = 1'b1;
				chans[n].phase = PH_LOAD;
			end
		end else if (m == 3'd3 || m == 3'd7) begin
			step_down(n);
			if (chans[n].count_val == 16'd0) begin
				set_level(n, ~chans[n].level);
				chans[n].count_val = chans[n].reload_val;
				chans[n].phase = PH_LOAD;
			end
		end
	endfunction

	function automatic void gate_edge(int n, logic g);
		logic [2:0] m;
		m = timer_mode(n);
		if (chans[n].phase != PH_RELOAD) begin
			if (!chans[n].prev_gate && g) begin
				if (m != 3'd0 && m != 3'd4)
					chans[n].phase = PH_LOAD;
			end else if (chans[n].prev_gate && !g) begin
				if (m == 3'd2 || m == 3'd3 || m == 3'd6 || m == 3'd7) begin
					set_level(n, 1'b1);
					chans[n].phase = PH_GATE;
				end else if (m == 3'd4) begin
					chans[n].phase = PH_GATE;
				end
			end
		end
		chans[n].prev_gate = g;
	endfunction

	function automatic void control_word(logic [7:0] v);
		int n;
		logic [2:0] m;
		n = v[7:6];
		if (n >= 3)
			return;
		if (v[5:4] == ACC_LATCH) begin
			chans[n].latched = chans[n].count_val;
			chans[n].held = 1'b1;
		end else begin
			chans[n].mode_word = v[5:0];
			chans[n].held = 1'b0;
			chans[n].count_val = '0;
			chans[n].phase = PH_RELOAD;
			chans[n].first_load = 1'b1;
			m = timer_mode(n);
			if (m == 3'd0) begin
				set_level(n, 1'b0);
				chans[n].load_level = 1'b0;
			end else begin
				set_level(n, 1'b1);
				chans[n].load_level = (m == 3'd2 || m == 3'd3 || m == 3'd6 || m == 3'd7);
			end
		end
		chans[n].byte_hi = 1'b0;
	endfunction

	function automatic void data_write(int n, logic [7:0] v);
		case (chans[n].mode_word[5:4])
			ACC_LSB: begin
				chans[n].staged = {8'h00, v};
				begin_load(n);
			end
			ACC_MSB: begin
				chans[n].staged = {v, 8'h00};
				begin_load(n);
			end
			ACC_BOTH: begin
				if (!chans[n].byte_hi) begin
					chans[n].staged[7:0] = v;
					chans[n].byte_hi = 1'b1;
					if (timer_mode(n) == 3'd0) begin
						set_level(n, 1'b0);
						chans[n].phase = PH_RELOAD;
					end
				end else begin
					chans[n].staged[15:8] = v;
					begin_load(n);
					chans[n].byte_hi = 1'b0;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic [7:0] data_read(int n);
		logic [7:0] r;
		r = '0;
		case (chans[n].mode_word[5:4])
			ACC_LSB: begin
				chans[n].held = 1'b0;
				r = chans[n].latched[7:0];
			end
			ACC_MSB: begin
				chans[n].held = 1'b0;
				r = chans[n].latched[15:8];
			end
			ACC_BOTH: begin
				if (!chans[n].byte_hi) begin
					r = chans[n].latched[7:0];
					chans[n].byte_hi = 1'b1;
				end else begin
					chans[n].held = 1'b0;
					r = chans[n].latched[15:8];
					chans[n].byte_hi = 1'b0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Apply one request to the predicted timer and return its response.
	function automatic rsp_t predict_response(req_t r);
		rsp_t res;
		res = '0;
		changed = '0;
		if (r.kind == KIND_TICK) begin
			for (int n = 0; n < 3; n++) begin
				gate_edge(n, r.gate_levels[n]);
				if (chans[n].phase == PH_LOAD) begin
					chans[n].count_val = chans[n].reload_val;
					chans[n].level = chans[n].load_level;
					chans[n].phase = PH_COUNT;
				end else if (chans[n].phase == PH_COUNT) begin
					count_chan(n);
				end
			end
		end else if (r.kind == KIND_READ) begin
			res.read_data = (r.port == PORT_CTRL) ? CTRL_READ : data_read(r.port);
		end else if (r.kind == KIND_WRITE) begin
			if (r.port == PORT_CTRL)
				control_word(r.write_data);
			else
				data_write(r.port, r.write_data);
		end
		for (int n = 0; n < 3; n++)
			res.out_levels[n] = chans[n].level;
		res.out_changed = changed;
		return res;
	endfunction

	assign pending = expected_rsps.size();

	// Predict on accepted requests and compare accepted responses.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int n = 0; n < 3; n++) begin
				chans[n] = '{default: '0};
				chans[n].first_load = 1'b1;
				chans[n].phase = PH_RELOAD;
			end
			expected_rsps.delete();
			errors = 0;
			checked = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response %h", $realtime, rsp_data);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					checked++;
					if (rsp_data.read_data !== want.read_data) begin
						$display("%0t: read_data expected %h actual %h", $realtime,
							want.read_data, rsp_data.read_data);
						errors++;
					end
					if (rsp_data.out_levels !== want.out_levels) begin
						$display("%0t: out_levels expected %b actual %b", $realtime,
							want.out_levels, rsp_data.out_levels);
						errors++;
					end
					if (rsp_data.out_changed !== want.out_changed) begin
						$display("%0t: out_changed expected %b actual %b", $realtime,
							want.out_changed, rsp_data.out_changed);
						errors++;
					end
				end
			end
			if (req_valid && req_ready)
				expected_rsps.push_back(predict_response(req_data));
		end
	end
endmodule

// ----- dv/tb.sv -----
// Testbench top: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 1ps
module tb;
	import itc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors;
	int pending;
	int checked;
	int cycles = 0;
	int sent = 0;
	bit long_hold = 1'b0;
	bit stim_done = 1'b0;

	itc_if #(.T(req_t)) req_ch ();
	itc_if #(.T(rsp_t)) rsp_ch ();

	interval_timer_three_channel_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	timer_check i_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_ch.valid),
		.req_ready(req_ch.ready),
		.req_data(req_ch.data),
		.rsp_valid(rsp_ch.valid),
		.rsp_ready(rsp_ch.ready),
		.rsp_data(rsp_ch.data),
		.errors(errors),
		.pending(pending),
		.checked(checked)
	);

	always #10 clk = ~clk;

	// Cycle limit guards against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 1000000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Random gap length: mostly short, sometimes long.
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 55)
			return 0;
		if (p < 93)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// Offer one request and hold it until the timer accepts it.
	task automatic send_req(logic [1:0] kind, logic [1:0] port, logic [7:0] wd,
			logic [2:0] gates);
		req_ch.valid <= 1'b1;
		req_ch.data <= '{kind: kind, port: port, write_data: wd, gate_levels: gates};
		do
			@(posedge clk);
		while (!req_ch.ready);
		sent++;
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= req_t'($urandom);
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic random_req(bit with_gap);
		int p;
		logic [1:0] kind;
		logic [1:0] port;
		logic [7:0] wd;
		p = $urandom_range(99);
		port = 2'($urandom_range(2));
		wd = 8'($urandom);
		// Ticks dominate so counters reach terminal counts; control words
		// mostly pick a valid channel with a working mode.
		if (p < 62) begin
			kind = KIND_TICK;
			wd = 8'($urandom);
		end else if (p < 72) begin
			kind = KIND_READ;
			if ($urandom_range(9) == 0)
				port = PORT_CTRL;
		end else if (p < 86) begin
			kind = KIND_WRITE;
			if ($urandom_range(3) == 0)
				wd = 8'($urandom_range(12));
		end else if (p < 98) begin
			kind = KIND_WRITE;
			port = PORT_CTRL;
			if ($urandom_range(4) == 0)
				wd = 8'($urandom);
			else
				wd = {2'($urandom_range(2)), 2'($urandom_range(3, 1)),
					3'($urandom_range(3)), 1'($urandom_range(9) == 0)};
		end else begin
			kind = 2'd3;
			port = 2'($urandom);
		end
		send_req(kind, port, wd, ($urandom_range(5) == 0) ? 3'($urandom) :
			3'b111);
		if (with_gap)
			idle_gap(gap_len());
	endtask

	// Receiver stalls, with one long hold-off during stimulus.
	initial begin
		int g;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (60) @(negedge clk);
				long_hold = 1'b0;
			end
			if (stim_done || $urandom_range(3) != 0) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				g = gap_len();
				rsp_ch.ready <= 1'b0;
				repeat (g) @(negedge clk);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int wait_cycles;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reads after reset, modes 0, 2, 3, latch, BCD and odd ports.
		send_req(KIND_READ, 2'd0, 8'h00, 3'b000);
		send_req(KIND_WRITE, 2'd1, 8'hFF, 3'b111);
		send_req(KIND_READ, PORT_CTRL, 8'h00, 3'b111);
		send_req(KIND_WRITE, PORT_CTRL, 8'hF0, 3'b111);
		send_req(KIND_WRITE, PORT_CTRL, 8'h30, 3'b111);
		send_req(KIND_WRITE, 2'd0, 8'h03, 3'b111);
		send_req(KIND_WRITE, 2'd0, 8'h00, 3'b111);
		repeat (5) send_req(KIND_TICK, 2'd0, 8'h00, 3'b111);
		send_req(KIND_WRITE, PORT_CTRL, 8'h54, 3'b111);
		send_req(KIND_WRITE, 2'd1, 8'h02, 3'b111);
		send_req(KIND_WRITE, PORT_CTRL, 8'hA7, 3'b111);
		send_req(KIND_WRITE, 2'd2, 8'h00, 3'b111);
		repeat (4) send_req(KIND_TICK, 2'd3, 8'hFF, 3'b000);
		send_req(KIND_WRITE, PORT_CTRL, 8'h00, 3'b111);
		send_req(KIND_READ, 2'd0, 8'h00, 3'b111);
		send_req(KIND_READ, 2'd0, 8'h00, 3'b111);
		send_req(2'd3, 2'd2, 8'hFF, 3'b111);

		// Random with gaps.
		repeat (900) random_req(1'b1);

		// Long receiver hold-off while requests keep coming back to back.
		long_hold = 1'b1;
		repeat (120) random_req(1'b0);

		// Pause until every expected response is back.
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		repeat (900) random_req($urandom_range(1));

		req_ch.valid <= 1'b0;
		stim_done = 1'b1;
		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 5000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (10) @(negedge clk);
		$display("Sent %0d requests and checked %0d responses over three channels,",
			sent, checked);
		$display("covering ticks, gates, bus reads and writes, and response stalls.");
		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+sv
sv/itc_pkg.sv
sv/itc_if.sv
sv/itc_lane.sv
sv/itc_merge.sv
sv/interval_timer_three_channel_top.sv
sv/itc_checker.sv
dv/timer_check.sv
dv/tb.sv
